[hw/rtl/lkv_pkg.sv]
package lkv_pkg;

  localparam int KEY_W = 64;
  localparam int VAL_W = 32;
  localparam int ACT_W = 2;
  localparam int CAP_W = 5;

  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 104;

  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic upd;
    logic clear;
    logic hit_mode;
    logic evict;
  } ctrl_t;

endpackage

[hw/rtl/lkv_cell.sv]
module lkv_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cmp_en,
  input  logic [lkv_pkg::KEY_W-1:0] cmp_key,
  input  lkv_pkg::ctrl_t            ctrl,
  input  lkv_pkg::entry_t           prev_i,
  input  logic                      sfx_i,
  output logic                      sfx_o,
  output logic                      match_o,
  output lkv_pkg::entry_t           entry_o
);

  logic                      valid_r, valid_nxt;
  logic [lkv_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [lkv_pkg::VAL_W-1:0] value_r, value_nxt;
  logic                      match_r;
  logic                      shift;

  // positions up to the hit slide back by one
  assign sfx_o = match_r | sfx_i;

  always_comb begin
    if (ctrl.hit_mode) begin
      shift = sfx_o;
    end else if (ctrl.evict) begin
      shift = valid_r;
    end else begin
      shift = prev_i.valid;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (ctrl.upd) begin
      if (ctrl.clear) begin
        valid_nxt = 1'b0;
      end else if (shift) begin
        valid_nxt = prev_i.valid;
        key_nxt   = prev_i.key;
        value_nxt = prev_i.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      match_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (cmp_en) begin
        match_r <= valid_r && (key_r == cmp_key);
      end
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

  assign match_o       = match_r;
  assign entry_o.valid = valid_r;
  assign entry_o.key   = key_r;
  assign entry_o.value = value_r;

endmodule

[hw/rtl/lru_key_value_cache.sv]
// channel   dir  tdata (low bit up)                          tuser
// in_       in   key[63:0], value[95:64]                     action[1:0]
// out_      out  hit[0], found_value[32:1], evicted[33],     -
//                evicted_key[97:34], zero[103:98]
// cfg_      in   capacity[4:0] on cfg_wr_en                  -
//
// On acceptance the key is compared against every cell; then, in the execute state,
// the recency chain shifts and the result is registered. One transaction is in the
// chain at a time. A stalled output holds the chain in its execute state; a new
// transaction is taken while the previous result still waits. Reset empties the
// cache at once.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [lkv_pkg::IN_DATA_W-1:0]  in_tdata,   // key, value
  input  logic [lkv_pkg::ACT_W-1:0]      in_tuser,   // action
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [lkv_pkg::OUT_DATA_W-1:0] out_tdata,  // hit, found_value, evicted, evicted_key
  input  logic                           cfg_wr_en,
  input  logic [lkv_pkg::CAP_W-1:0]      cfg_wr_data // capacity
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int MW = (CW > lkv_pkg::CAP_W) ? CW : lkv_pkg::CAP_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                        state_r, state_nxt;
  logic [lkv_pkg::CAP_W-1:0]   cap_r;
  logic [CW-1:0]               count_r, count_nxt;
  logic [lkv_pkg::ACT_W-1:0]   act_r;
  logic [lkv_pkg::KEY_W-1:0]   key_r;
  logic [lkv_pkg::VAL_W-1:0]   val_r;

  logic                        out_valid_r;
  logic                        hit_r, evicted_r;
  logic [lkv_pkg::VAL_W-1:0]   fv_r;
  logic [lkv_pkg::KEY_W-1:0]   ek_r;

  logic                        in_acc, fire;
  logic [MW-1:0]               cap_eff, count_ext;
  logic                        is_lookup, is_insert, is_clear, any_hit, evict;
  logic [lkv_pkg::VAL_W-1:0]   found_val;
  logic [lkv_pkg::KEY_W-1:0]   last_key;

  lkv_pkg::ctrl_t              ctrl;
  lkv_pkg::entry_t             front;
  lkv_pkg::entry_t             entry_w [ENTRIES];
  logic [ENTRIES:0]            sfx_w;
  logic [ENTRIES:0]            valid_v;
  logic [ENTRIES-1:0]          match_w;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign fire      = (state_r == ST_EXEC) && (!out_valid_r || out_tready);

  assign cap_eff   = (MW'(cap_r) > MW'(ENTRIES)) ? MW'(ENTRIES) : MW'(cap_r);
  assign count_ext = MW'(count_r);

  assign is_lookup = (act_r == lkv_pkg::ACT_LOOKUP);
  assign is_insert = (act_r == lkv_pkg::ACT_INSERT) && (cap_eff != '0);
  assign is_clear  = (act_r == lkv_pkg::ACT_CLEAR);
  assign any_hit   = sfx_w[0];
  assign evict     = (count_ext >= cap_eff);

  assign sfx_w[ENTRIES]   = 1'b0;
  assign valid_v[ENTRIES] = 1'b0;

  always_comb begin
    found_val = '0;
    last_key  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_w[i]) begin
        found_val = found_val | entry_w[i].value;
      end
      if (valid_v[i] && !valid_v[i+1]) begin
        last_key = last_key | entry_w[i].key;
      end
    end
  end

  always_comb begin
    ctrl.upd      = fire && ((is_lookup && any_hit) || is_insert || is_clear);
    ctrl.clear    = is_clear;
    ctrl.hit_mode = any_hit;
    ctrl.evict    = is_insert && !any_hit && evict;
    front.valid   = 1'b1;
    front.key     = key_r;
    front.value   = is_insert ? val_r : found_val;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lkv_pkg::entry_t prev;
    if (i == 0) begin : g_head
      assign prev = front;
    end else begin : g_link
      assign prev = entry_w[i-1];
    end
    assign valid_v[i] = entry_w[i].valid;

    lkv_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmp_en  (in_acc),
      .cmp_key (in_tdata[lkv_pkg::KEY_W-1:0]),
      .ctrl    (ctrl),
      .prev_i  (prev),
      .sfx_i   (sfx_w[i+1]),
      .sfx_o   (sfx_w[i]),
      .match_o (match_w[i]),
      .entry_o (entry_w[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (fire) begin
      if (is_clear) begin
        count_nxt = '0;
      end else if (is_insert && !any_hit && !evict) begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= lkv_pkg::CAP_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r <= in_tuser;
      key_r <= in_tdata[lkv_pkg::KEY_W-1:0];
      val_r <= in_tdata[lkv_pkg::KEY_W +: lkv_pkg::VAL_W];
    end
    if (fire) begin
      hit_r     <= (is_lookup || is_insert) && any_hit;
      fv_r      <= (is_lookup && any_hit) ? found_val : '0;
      evicted_r <= ctrl.evict;
      ek_r      <= ctrl.evict ? last_key : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, ek_r, evicted_r, fv_r, hit_r};

endmodule

[hw/rtl/lkv_checker.sv]
module lkv_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [lkv_pkg::OUT_DATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output transaction changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while chain busy");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |-> ##2 out_tvalid)
    else $error("result missing two cycles after accept");

  a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[33]))
    else $error("hit and eviction in one result");

  a_value_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[32:1] == '0)
    else $error("found value without hit");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
